// ===== src/bfa_pkg.sv =====
`timescale 1ns / 1ps

package bfa_pkg;

  // Default geometry of the frame map
  localparam int unsigned NUM_FRAMES_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 32;

  // Field widths
  localparam int unsigned FRAME_W  = 12;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STATUS_W = 2;

  // Reset value of the frame count register
  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NO_CHANGE = 2'd1,
    STATUS_NO_FRAME  = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;    // capture item, rewind the word walk
    logic clr_step;     // write one zero word of the clearing pass
    logic walk_step;    // advance the word walk by one word
    logic rd_issue;     // read the map word under the walk
    logic alloc_write;  // mark the lowest clear bit of the read word, set done result
    logic free_write;   // clear the freed bit of the read word
    logic res_skip;     // set no-change result
    logic res_fail;     // set no-free-frame result
    logic res_free;     // set free result
    logic out_load;     // move result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;    // clearing pass at its last word
    logic op_free;     // held item is a free
    logic frame_zero;  // held item names no frame
    logic walk_end;    // no further word in the search range
    logic rd_vld;      // read data of the last issued word is present
    logic word_hit;    // that word has a clear bit
    logic seek_hit;    // walk word holds the frame to free
    logic seek_end;    // walk ran past the map
    logic out_busy;    // output register holds an item not taken this cycle
  } sts_t;

endpackage

// ===== src/bfa_if.sv =====
`timescale 1ns / 1ps

// Request channel
interface bfa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [bfa_pkg::FRAME_W-1:0]  page_frame;
  logic                         is_kernel;
  logic                         is_writeable;

  modport source (output valid, output op, output page_frame, output is_kernel,
                  output is_writeable, input ready);
  modport sink   (input valid, input op, input page_frame, input is_kernel,
                  input is_writeable, output ready);
endinterface

// Response channel
interface bfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bfa_pkg::FRAME_W-1:0]   frame_out;
  logic                          present;
  logic                          writable;
  logic                          user_mode;
  logic [bfa_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output frame_out, output present, output writable,
                  output user_mode, output status, input ready);
  modport sink   (input valid, input frame_out, input present, input writable,
                  input user_mode, input status, output ready);
endinterface

// ===== src/bfa_ram.sv =====
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int unsigned WIDTH = bfa_pkg::WORD_BITS_DEF,
  parameter int unsigned DEPTH = bfa_pkg::NUM_FRAMES_DEF / bfa_pkg::WORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bfa_datapath.sv =====
`timescale 1ns / 1ps

module bfa_datapath #(
  parameter int unsigned NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
  parameter int unsigned WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bfa_pkg::COUNT_W-1:0]     cfg_data_i,
  input  logic                            req_op_i,
  input  logic [bfa_pkg::FRAME_W-1:0]     req_page_frame_i,
  input  logic                            req_is_kernel_i,
  input  logic                            req_is_writeable_i,
  input  logic                            rsp_ready_i,
  input  bfa_pkg::cmd_t                   cmd_i,
  output bfa_pkg::sts_t                   sts_o,
  output logic                            rsp_valid_o,
  output logic [bfa_pkg::FRAME_W-1:0]     rsp_frame_out_o,
  output logic                            rsp_present_o,
  output logic                            rsp_writable_o,
  output logic                            rsp_user_mode_o,
  output logic [bfa_pkg::STATUS_W-1:0]    rsp_status_o
);

  localparam int unsigned MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned WCNT_W    = $clog2(MAP_WORDS + 1);
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned BASE_W    =
    $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + (1 << bfa_pkg::COUNT_W));
  localparam logic [WCNT_W-1:0] WORDS_END  = WCNT_W'(MAP_WORDS);
  localparam logic [WCNT_W-1:0] WORDS_LAST = WCNT_W'(MAP_WORDS - 1);
  localparam logic [BASE_W-1:0] WORD_STEP  = BASE_W'(WORD_BITS);

  // Configuration and control registers
  logic [bfa_pkg::COUNT_W-1:0]  frame_count_q;
  logic [WCNT_W-1:0]            clr_addr_q;
  logic                         rd_vld_q;
  logic                         out_valid_q;

  // Item and walk registers
  logic                         op_q;
  logic [bfa_pkg::FRAME_W-1:0]  page_frame_q;
  logic                         is_kernel_q;
  logic                         is_writeable_q;
  logic [WCNT_W-1:0]            walk_w_q;
  logic [BASE_W-1:0]            walk_base_q;
  logic [ADDR_W-1:0]            rd_addr_q;
  logic [BASE_W-1:0]            rd_base_q;

  // Result and output registers
  logic [bfa_pkg::FRAME_W-1:0]  res_frame_q;
  logic                         res_present_q;
  logic                         res_writable_q;
  logic                         res_user_q;
  bfa_pkg::status_e             res_status_q;
  logic [bfa_pkg::FRAME_W-1:0]  out_frame_q;
  logic                         out_present_q;
  logic                         out_writable_q;
  logic                         out_user_q;
  bfa_pkg::status_e             out_status_q;

  // Map access
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [WORD_BITS-1:0]         ram_wdata;
  logic [WORD_BITS-1:0]         ram_rdata;

  logic [BASE_W-1:0]            pf_ext;
  logic [BASE_W-1:0]            fc_ext;
  logic [BASE_W-1:0]            next_base;
  logic [BIT_W-1:0]             clr_idx;
  logic [BASE_W-1:0]            alloc_frame;
  logic [BASE_W-1:0]            free_off;
  logic [WORD_BITS-1:0]         alloc_mask;
  logic [WORD_BITS-1:0]         free_mask;

  assign pf_ext    = BASE_W'(page_frame_q);
  assign fc_ext    = BASE_W'(frame_count_q);
  assign next_base = walk_base_q + WORD_STEP;

  // Find the lowest clear bit of the word just read
  always_comb begin
    clr_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!ram_rdata[b]) begin
        clr_idx = BIT_W'(b);
      end
    end
  end

  assign alloc_frame = rd_base_q + BASE_W'(clr_idx);
  assign alloc_mask  = WORD_BITS'(1) << clr_idx;
  assign free_off    = pf_ext - rd_base_q;
  assign free_mask   = WORD_BITS'(1) << free_off[BIT_W-1:0];

  // Status toward the controller
  always_comb begin
    sts_o.clr_last   = (clr_addr_q == WORDS_LAST);
    sts_o.op_free    = (op_q == bfa_pkg::OP_FREE);
    sts_o.frame_zero = (page_frame_q == '0);
    sts_o.walk_end   = (walk_w_q == WORDS_END) || (next_base > fc_ext);
    sts_o.rd_vld     = rd_vld_q;
    sts_o.word_hit   = rd_vld_q && !(&ram_rdata);
    sts_o.seek_hit   = (walk_w_q != WORDS_END) && (pf_ext < next_base);
    sts_o.seek_end   = (walk_w_q == WORDS_END);
    sts_o.out_busy   = out_valid_q && !rsp_ready_i;
  end

  // Select the map write: clearing pass, set on allocate, clear on free
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr_q;
    ram_wdata = ram_rdata;
    priority if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q[ADDR_W-1:0];
      ram_wdata = '0;
    end else if (cmd_i.alloc_write) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata | alloc_mask;
    end else if (cmd_i.free_write) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata & ~free_mask;
    end else begin
      ram_we    = 1'b0;
    end
  end

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (walk_w_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= bfa_pkg::FRAME_COUNT_RST;
      clr_addr_q    <= '0;
      rd_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_count_q <= cfg_data_i;
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + WCNT_W'(1);
      end
      rd_vld_q <= cmd_i.rd_issue;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, walk, result and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q           <= req_op_i;
      page_frame_q   <= req_page_frame_i;
      is_kernel_q    <= req_is_kernel_i;
      is_writeable_q <= req_is_writeable_i;
      walk_w_q       <= '0;
      walk_base_q    <= '0;
    end else if (cmd_i.walk_step) begin
      walk_w_q    <= walk_w_q + WCNT_W'(1);
      walk_base_q <= next_base;
    end
    if (cmd_i.rd_issue) begin
      rd_addr_q <= walk_w_q[ADDR_W-1:0];
      rd_base_q <= walk_base_q;
    end
    priority if (cmd_i.alloc_write) begin
      res_frame_q    <= alloc_frame[bfa_pkg::FRAME_W-1:0];
      res_present_q  <= 1'b1;
      res_writable_q <= is_writeable_q;
      res_user_q     <= ~is_kernel_q;
      res_status_q   <= bfa_pkg::STATUS_DONE;
    end else if (cmd_i.res_skip) begin
      res_frame_q    <= (op_q == bfa_pkg::OP_FREE) ? '0 : page_frame_q;
      res_present_q  <= 1'b0;
      res_writable_q <= 1'b0;
      res_user_q     <= 1'b0;
      res_status_q   <= bfa_pkg::STATUS_NO_CHANGE;
    end else if (cmd_i.res_fail) begin
      res_frame_q    <= '0;
      res_present_q  <= 1'b0;
      res_writable_q <= 1'b0;
      res_user_q     <= 1'b0;
      res_status_q   <= bfa_pkg::STATUS_NO_FRAME;
    end else if (cmd_i.res_free) begin
      res_frame_q    <= '0;
      res_present_q  <= 1'b0;
      res_writable_q <= 1'b0;
      res_user_q     <= 1'b0;
      res_status_q   <= bfa_pkg::STATUS_DONE;
    end else begin
      // hold the result
      res_status_q   <= res_status_q;
    end
    if (cmd_i.out_load) begin
      out_frame_q    <= res_frame_q;
      out_present_q  <= res_present_q;
      out_writable_q <= res_writable_q;
      out_user_q     <= res_user_q;
      out_status_q   <= res_status_q;
    end
  end

  assign rsp_valid_o     = out_valid_q;
  assign rsp_frame_out_o = out_frame_q;
  assign rsp_present_o   = out_present_q;
  assign rsp_writable_o  = out_writable_q;
  assign rsp_user_mode_o = out_user_q;
  assign rsp_status_o    = out_status_q;

endmodule

// ===== src/bfa_ctrl.sv =====
`timescale 1ns / 1ps

module bfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  bfa_pkg::sts_t  sts_i,
  output logic           req_ready_o,
  output bfa_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SEEK,
    ST_FREE_WR,
    ST_RESP
  } state_e;

  state_e state_q;
  state_e state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.op_free == sts_i.frame_zero) begin
          // allocate for a page with a frame, or free of no frame
          cmd_o.res_skip = 1'b1;
          state_d        = ST_RESP;
        end else if (sts_i.op_free) begin
          state_d = ST_SEEK;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.word_hit) begin
          cmd_o.alloc_write = 1'b1;
          state_d           = ST_RESP;
        end else if (sts_i.walk_end) begin
          // drain the last read before giving up
          if (!sts_i.rd_vld) begin
            cmd_o.res_fail = 1'b1;
            state_d        = ST_RESP;
          end
        end else begin
          cmd_o.rd_issue  = 1'b1;
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_SEEK: begin
        if (sts_i.seek_hit) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_FREE_WR;
        end else if (sts_i.seek_end) begin
          // frame lies beyond the map: report done, touch nothing
          cmd_o.res_free = 1'b1;
          state_d        = ST_RESP;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_FREE_WR: begin
        cmd_o.free_write = 1'b1;
        cmd_o.res_free   = 1'b1;
        state_d          = ST_RESP;
      end
      ST_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);

endmodule

// ===== src/bitmap_frame_allocator.sv =====
`timescale 1ns / 1ps

// First-fit physical frame allocator over a one-bit-per-frame used map.
// Requests come in on req_i (valid/ready); an item is taken when both are
// high. op 0 allocates a frame for a page holding none, op 1 frees the
// page's frame. Every item gives exactly one item on rsp_o (valid/ready),
// carrying the frame, the page-entry bits and a status code.
// frame_count is to be written through cfg_we_i/cfg_data_i while the block
// is idle; the block does not enforce this. Only whole map words below
// frame_count are searched. An item needing no change goes straight to its
// result. An allocation and a free both walk the map one word per cycle: an
// allocation reads each word through the single read port of the map memory
// until a word with a clear bit turns up or the search range ends; a free
// reads and rewrites only the word holding its frame, and reports done
// without touching the map for a frame beyond it. One item is in work at a
// time; req_i.ready rises again in the same cycle as the result shows on
// rsp_o. After reset the map is cleared one word per cycle before
// req_i.ready rises.
// The result sits in an output register: a stalled receiver holds it there,
// and the block stays busy with a finished item until that register frees.

module bitmap_frame_allocator #(
  parameter int unsigned NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
  parameter int unsigned WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bfa_pkg::COUNT_W-1:0]  cfg_data_i,
  bfa_req_if.sink                      req_i,
  bfa_rsp_if.source                    rsp_o
);

  bfa_pkg::cmd_t  cmd;
  bfa_pkg::sts_t  sts;
  logic           req_ready;

  bfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .sts_i       (sts),
    .req_ready_o (req_ready),
    .cmd_o       (cmd)
  );

  bfa_datapath #(
    .NUM_FRAMES (NUM_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .req_op_i           (req_i.op),
    .req_page_frame_i   (req_i.page_frame),
    .req_is_kernel_i    (req_i.is_kernel),
    .req_is_writeable_i (req_i.is_writeable),
    .rsp_ready_i        (rsp_o.ready),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .rsp_valid_o        (rsp_o.valid),
    .rsp_frame_out_o    (rsp_o.frame_out),
    .rsp_present_o      (rsp_o.present),
    .rsp_writable_o     (rsp_o.writable),
    .rsp_user_mode_o    (rsp_o.user_mode),
    .rsp_status_o       (rsp_o.status)
  );

  assign req_i.ready = req_ready;

endmodule
